// File: design/trial_division_prime_test_defines.svh
// ----------------------------------------------------------------------------
// Trial division prime test assertion macros
// Shared assertion forms for the trial division prime test block.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Widths, microcode encodings and the control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    localparam int NUMBER_BITS        = 32;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int OUT_TDATA_BITS     = 8;
    localparam int PC_BITS            = 4;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_INIT      = 3'd2,
        OP_DIV_INIT  = 3'd3,
        OP_DIV_STEP  = 3'd4,
        OP_NEXT_D    = 3'd5,
        OP_PUSH      = 3'd6,
        OP_SET_PRIME = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER      = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NOT_ACCEPT = 3'd2,
        COND_V_LT2      = 3'd3,
        COND_SQ_GT_V    = 3'd4,
        COND_CNT_NZ     = 3'd5,
        COND_REM_NZ     = 3'd6,
        COND_OUT_BUSY   = 3'd7
    } cond_t;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } ctrl_t;

    localparam logic [PC_BITS-1:0] STEP_WAIT   = 4'd0;
    localparam logic [PC_BITS-1:0] STEP_INIT   = 4'd1;
    localparam logic [PC_BITS-1:0] STEP_TEST   = 4'd2;
    localparam logic [PC_BITS-1:0] STEP_DSTART = 4'd3;
    localparam logic [PC_BITS-1:0] STEP_DSTEP  = 4'd4;
    localparam logic [PC_BITS-1:0] STEP_DCHECK = 4'd5;
    localparam logic [PC_BITS-1:0] STEP_EMIT   = 4'd6;
    localparam logic [PC_BITS-1:0] STEP_RETURN = 4'd7;
    localparam logic [PC_BITS-1:0] STEP_PRIME  = 4'd8;

    function automatic ctrl_t micro_rom(input logic [PC_BITS-1:0] addr);
        ctrl_t word;
        case (addr)
            STEP_WAIT:   word = '{OP_LOAD,      COND_NOT_ACCEPT, STEP_WAIT};
            STEP_INIT:   word = '{OP_INIT,      COND_V_LT2,      STEP_EMIT};
            STEP_TEST:   word = '{OP_NONE,      COND_SQ_GT_V,    STEP_PRIME};
            STEP_DSTART: word = '{OP_DIV_INIT,  COND_NEVER,      STEP_WAIT};
            STEP_DSTEP:  word = '{OP_DIV_STEP,  COND_CNT_NZ,     STEP_DSTEP};
            STEP_DCHECK: word = '{OP_NEXT_D,    COND_REM_NZ,     STEP_TEST};
            STEP_EMIT:   word = '{OP_PUSH,      COND_OUT_BUSY,   STEP_EMIT};
            STEP_RETURN: word = '{OP_NONE,      COND_ALWAYS,     STEP_WAIT};
            STEP_PRIME:  word = '{OP_SET_PRIME, COND_ALWAYS,     STEP_EMIT};
            default:     word = '{OP_NONE,      COND_ALWAYS,     STEP_WAIT};
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// File: design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Answers whether an unsigned number is prime by trying divisors d from two
// upward while d squared does not exceed it, stopping at the first that divides.
// ----------------------------------------------------------------------------
// Usage:
// A number enters on the slave stream (s_axis_*) and one word carrying the
// answer leaves on the master stream (m_axis_*); one number is in work at a
// time. A microcoded sequencer steps through a small control store and drives
// a datapath with the divisor, its running square and a restoring divider
// that retires one remainder bit per cycle.
// Steps: a taken number passes the init step, which sends zero and one
// straight to the emit step. Otherwise each trial divisor runs the test,
// divider start, bit-serial remainder loop and check steps, and a prime is
// marked once the divisor square passes the number; the emit and return
// steps then lead back to the wait step.
// The answer waits in an output register; a new number is taken as soon as
// the sequencer returns to its wait step, even while that answer stalls.
// If the receiver holds tready low when the next answer is ready, the
// sequencer waits at its emit step until the register frees.
// Reset clears the sequencer and drops any pending answer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output      logic                      s_axis_tready,
    input  wire logic [NUMBER_BITS-1:0]    s_axis_tdata,   // [31:0] number
    output      logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output      logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // [0] is_prime, [7:1] zero
);

    localparam int IN_BITS  = (VALUE_BITS < NUMBER_BITS) ? VALUE_BITS : NUMBER_BITS;
    localparam int CNT_BITS = $clog2(VALUE_BITS);

    logic [PC_BITS-1:0]    pc_reg, pc_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_data_reg, out_data_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS:0]   sq_reg, sq_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  result_reg, result_next;

    ctrl_t                 ctrl;
    logic                  s_accept;
    logic                  out_busy;
    logic                  cond_true;
    logic [VALUE_BITS:0]   trial;

    assign ctrl          = micro_rom(pc_reg);
    assign s_axis_tready = (ctrl.op == OP_LOAD);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign trial         = {rem_reg, shift_reg[VALUE_BITS-1]};

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_NOT_ACCEPT: cond_true = !s_accept;
            COND_V_LT2:      cond_true = (v_reg < VALUE_BITS'(2));
            COND_SQ_GT_V:    cond_true = (sq_reg > {1'b0, v_reg});
            COND_CNT_NZ:     cond_true = (cnt_reg != '0);
            COND_REM_NZ:     cond_true = (rem_reg != '0);
            COND_OUT_BUSY:   cond_true = out_busy;
            default:         cond_true = 1'b0;
        endcase
        pc_next = cond_true ? ctrl.target : pc_reg + PC_BITS'(1);
    end

    always_comb
    begin
        v_next         = v_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (s_accept)
                begin
                    v_next = VALUE_BITS'(s_axis_tdata[IN_BITS-1:0]);
                end
            end
            OP_INIT:
            begin
                d_next      = VALUE_BITS'(2);
                sq_next     = (VALUE_BITS + 1)'(4);
                result_next = 1'b0;
            end
            OP_DIV_INIT:
            begin
                rem_next   = '0;
                shift_next = v_reg;
                cnt_next   = CNT_BITS'(VALUE_BITS - 1);
            end
            OP_DIV_STEP:
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    rem_next = VALUE_BITS'(trial - {1'b0, d_reg});
                end
                else
                begin
                    rem_next = trial[VALUE_BITS-1:0];
                end
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg - CNT_BITS'(1);
            end
            OP_NEXT_D:
            begin
                d_next  = d_reg + VALUE_BITS'(1);
                sq_next = sq_reg + {d_reg, 1'b1};
            end
            OP_PUSH:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                end
            end
            OP_SET_PRIME:
            begin
                result_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        cnt_reg      <= cnt_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - 1){1'b0}}, out_data_reg};

    `TDPT_ASSERT_NEXT(a_accept_starts, s_accept, pc_reg == STEP_INIT,
        "Accepted number did not start the test sequence.")
    `TDPT_ASSERT_SAME(a_rem_below_divisor, pc_reg == STEP_DSTEP, rem_reg < d_reg,
        "Partial remainder reached the divisor.")
    `TDPT_ASSERT_SAME(a_prime_bound, (pc_reg == STEP_EMIT) && result_reg,
        sq_reg > {1'b0, v_reg},
        "Prime answer given before the divisor square passed the number.")

endmodule

`default_nettype wire

// File: dv/trial_division_prime_test_tb.sv
// ----------------------------------------------------------------------------
// Trial division prime test testbench
// Streams numbers into the prime tester and compares each answer word with
// an answer computed locally by trial division. A short list of edge values
// runs first, then random numbers in four phases with and without idle
// cycles on the input side and backpressure on the output side. Most numbers
// are small or carry a small factor, which keeps the divisor loop short.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tdpt_pkg::*;

    localparam int RANDOM_PER_PHASE = 20;
    localparam int WATCHDOG_LIMIT   = 400000;
    localparam int SETTLE_CYCLES    = 50;

    class prime_scoreboard;
        bit answers_due[$];
        int mismatches;
        int answers_seen;
        int primes_seen;

        function new();
            mismatches   = 0;
            answers_seen = 0;
            primes_seen  = 0;
        endfunction

        function bit prime_of(logic [NUMBER_BITS-1:0] raw);
            logic [63:0] v;
            logic [63:0] d;
            v = 64'(raw);
            if (v < 64'd2)
                return 1'b0;
            if (v <= 64'd3)
                return 1'b1;
            for (d = 64'd2; d <= v / d; d++)
            begin
                if (v % d == 64'd0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void add_number(logic [NUMBER_BITS-1:0] number);
            answers_due.push_back(prime_of(number));
        endfunction

        function void check_answer(logic [OUT_TDATA_BITS-1:0] word);
            bit want;
            if (answers_due.size() == 0)
            begin
                $error("unexpected answer word %0h with no number outstanding", word);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            answers_seen++;
            if (word[0])
                primes_seen++;
            if (word[0] !== want)
            begin
                $error("is_prime mismatch: expected %0d, actual %0d", want, word[0]);
                mismatches++;
            end
            if (word[OUT_TDATA_BITS-1:1] !== '0)
            begin
                $error("pad mismatch: expected 0, actual %0h", word[OUT_TDATA_BITS-1:1]);
                mismatches++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [NUMBER_BITS-1:0]    s_axis_tdata  = '0;  // [31:0] number
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // [0] is_prime, [7:1] zero

    prime_scoreboard sb = new();
    int idle_pct      = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;
    int numbers_sent  = 0;

    trial_division_prime_test dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
            #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.add_number(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_answer(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_number(input logic [NUMBER_BITS-1:0] number);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= number;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        numbers_sent++;
    endtask

    task automatic wait_all_answers();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly small numbers; large ones are rounded down to a multiple of a
    // small prime so that the divisor loop stops early.
    function automatic logic [NUMBER_BITS-1:0] random_number();
        int unsigned pick;
        int unsigned factor;
        logic [NUMBER_BITS-1:0] raw;
        pick = $urandom_range(99);
        if (pick < 15)
            return NUMBER_BITS'($urandom_range(15));
        if (pick < 60)
            return NUMBER_BITS'($urandom_range(4095));
        if (pick < 70)
            return NUMBER_BITS'($urandom_range(65535));
        case ($urandom_range(4))
            0:       factor = 2;
            1:       factor = 3;
            2:       factor = 5;
            3:       factor = 7;
            default: factor = 11;
        endcase
        raw = $urandom;
        return raw - (raw % factor);
    endfunction

    task automatic run_phase(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_number(random_number());
        wait_all_answers();
    endtask

    initial
    begin
        logic [NUMBER_BITS-1:0] edge_values[$];
        edge_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                        32'd49, 32'd97, 32'd121, 32'd4097, 32'd63001, 32'd65521,
                        32'd131042, 32'd1000003, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFE};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (edge_values[i])
            send_number(edge_values[i]);
        wait_all_answers();

        run_phase(0, 0);
        run_phase(69, 0);
        run_phase(0, 69);
        run_phase(29, 29);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d answers never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Sent %0d numbers (edge values, then random phases with idle and stall).",
                 numbers_sent);
        $display("Checked %0d answers, %0d of them prime.", sb.answers_seen, sb.primes_seen);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
